FILE: hdl/spim_pkg.sv
// Package for the sparse paged ID map: sizes, request and status codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package spim_pkg;

  localparam int PAGE_SLOTS = 64;
  localparam int DIR_DEPTH  = 16;
  localparam int VAL_W      = 256;
  localparam int ID_W       = 64;
  localparam int SLOT_W     = $clog2(PAGE_SLOTS);
  localparam int PAGE_W     = ID_W - SLOT_W;
  localparam int DIR_W      = $clog2(DIR_DEPTH);
  localparam int CNT_W      = $clog2(DIR_DEPTH + 1);
  localparam int POP_W      = $clog2(PAGE_SLOTS + 1);
  localparam int TOT_W      = 11;
  localparam int MEM_DEPTH  = DIR_DEPTH * PAGE_SLOTS;
  localparam int MADDR_W    = DIR_W + SLOT_W;
  localparam int MAX_ITER   = DIR_DEPTH + 2;
  localparam int ITER_W     = $clog2(MAX_ITER + 1);

  // Request codes.
  localparam logic [2:0] REQ_GET   = 3'd0;
  localparam logic [2:0] REQ_PUT   = 3'd1;
  localparam logic [2:0] REQ_DEL   = 3'd2;
  localparam logic [2:0] REQ_ALLOC = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_NOFREE   = 3'd2;
  localparam logic [2:0] ST_INVAL    = 3'd3;
  localparam logic [2:0] ST_DIRFULL  = 3'd4;

  typedef struct packed {
    logic       load;
    logic       srch_init;
    logic       srch_step;
    logic       slot_init;
    logic       slot_inc;
    logic       rd_issue;
    logic       wr_put;
    logic       wr_del;
    logic       create;
    logic       fill_step;
    logic       clear_all;
    logic       next_page;
    logic       fin;
    logic       fin_rd;
    logic       fin_found_id;
    logic       fin_found_slot;
    logic [2:0] fin_status;
  } ctl_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       val_zero;
    logic       srch_done;
    logic       has;
    logic       dir_full;
    logic       pop_full;
    logic       slot_empty;
    logic       slot_last;
    logic       slot_at_end;
    logic       loop_stop;
    logic       page_top;
    logic       fill_last;
  } dp_stat_t;

endpackage

FILE: hdl/sparse_paged_id_map_core.sv
// Sparse paged ID map, top level. One request at a time, one result each.
// Get and delete take a binary directory search; put on a new page adds a
// sweep that clears all its slots; allocate takes a directory search per page
// and a slot read per scanned slot, up to 18 pages. A new request is taken in the
// result cycle. Reset empties the directory; the receiver cannot stall.
module sparse_paged_id_map_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [2:0]                  req_type_i,
  input  logic [63:0]                 id_i,
  input  logic [63:0]                 alloc_limit_i,
  input  logic [63:0]                 value_w0_i,
  input  logic [63:0]                 value_w1_i,
  input  logic [63:0]                 value_w2_i,
  input  logic [63:0]                 value_w3_i,
  output logic                        done_o,
  output logic [2:0]                  status_o,
  output logic [63:0]                 read_w0_o,
  output logic [63:0]                 read_w1_o,
  output logic [63:0]                 read_w2_o,
  output logic [63:0]                 read_w3_o,
  output logic [63:0]                 found_id_o,
  output logic [spim_pkg::TOT_W-1:0]  total_entries_o,
  output logic [spim_pkg::CNT_W-1:0]  live_pages_o
);
  import spim_pkg::*;

  ctl_cmd_t         cmd;
  dp_stat_t         stat;
  logic [VAL_W-1:0] read_val;

  spim_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  spim_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .req_type_i     (req_type_i),
    .id_i           (id_i),
    .alloc_limit_i  (alloc_limit_i),
    .value_w0_i     (value_w0_i),
    .value_w1_i     (value_w1_i),
    .value_w2_i     (value_w2_i),
    .value_w3_i     (value_w3_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .read_o         (read_val),
    .found_id_o     (found_id_o),
    .total_entries_o(total_entries_o),
    .live_pages_o   (live_pages_o)
  );

  assign read_w0_o = read_val[63:0];
  assign read_w1_o = read_val[127:64];
  assign read_w2_o = read_val[191:128];
  assign read_w3_o = read_val[255:192];

  // A result is shown only once the controller is back to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobe while busy");

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("request transfer not held");

  // Every live page holds at least one entry.
  a_live_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (TOT_W'(live_pages_o) <= total_entries_o))
    else $error("live page count exceeds entry count");

endmodule

FILE: hdl/spim_ctrl.sv
// Controller state machine of the sparse paged ID map.
// Depends on spim_pkg; drives the datapath by commands only.
module spim_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  spim_pkg::dp_stat_t stat_i,
  output spim_pkg::ctl_cmd_t cmd_o
);
  import spim_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_SEARCH = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_CHECK  = 4'd4;
  localparam logic [3:0] S_FILL   = 4'd5;
  localparam logic [3:0] S_LOOP   = 4'd6;
  localparam logic [3:0] S_SCAN   = 4'd7;
  localparam logic [3:0] S_NEXT   = 4'd8;

  logic [3:0] state_q, state_d;

  assign busy_o = (state_q != S_IDLE);

  // Next state and command decode.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat_i.req) inside
          REQ_GET, REQ_DEL: begin
            cmd_o.srch_init = 1'b1;
            cmd_o.slot_init = 1'b1;
            state_d         = S_SEARCH;
          end
          REQ_PUT: begin
            if (stat_i.val_zero) begin
              cmd_o.fin        = 1'b1;
              cmd_o.fin_status = ST_INVAL;
              state_d          = S_IDLE;
            end else begin
              cmd_o.srch_init = 1'b1;
              cmd_o.slot_init = 1'b1;
              state_d         = S_SEARCH;
            end
          end
          REQ_ALLOC: state_d = S_LOOP;
          REQ_CLEAR: begin
            cmd_o.clear_all  = 1'b1;
            cmd_o.fin        = 1'b1;
            cmd_o.fin_status = ST_OK;
            state_d          = S_IDLE;
          end
          default: begin
            cmd_o.fin        = 1'b1;
            cmd_o.fin_status = ST_OK;
            state_d          = S_IDLE;
          end
        endcase
      end
      S_SEARCH: begin
        if (stat_i.srch_done) begin
          state_d = S_DECIDE;
        end else begin
          cmd_o.srch_step = 1'b1;
        end
      end
      S_DECIDE: begin
        unique case (stat_i.req) inside
          REQ_GET, REQ_DEL: begin
            if (!stat_i.has) begin
              cmd_o.fin        = 1'b1;
              cmd_o.fin_status = ST_NOTFOUND;
              state_d          = S_IDLE;
            end else begin
              cmd_o.rd_issue = 1'b1;
              state_d        = S_CHECK;
            end
          end
          REQ_PUT: begin
            if (stat_i.has) begin
              cmd_o.rd_issue = 1'b1;
              state_d        = S_CHECK;
            end else if (stat_i.dir_full) begin
              cmd_o.fin        = 1'b1;
              cmd_o.fin_status = ST_DIRFULL;
              state_d          = S_IDLE;
            end else begin
              cmd_o.create = 1'b1;
              state_d      = S_FILL;
            end
          end
          default: begin
            if (!stat_i.has) begin
              cmd_o.fin          = 1'b1;
              cmd_o.fin_found_id = 1'b1;
              cmd_o.fin_status   = ST_OK;
              state_d            = S_IDLE;
            end else if (!stat_i.pop_full) begin
              cmd_o.slot_init = 1'b1;
              state_d         = S_SCAN;
            end else begin
              state_d = S_NEXT;
            end
          end
        endcase
      end
      S_CHECK: begin
        unique case (stat_i.req) inside
          REQ_GET: begin
            cmd_o.fin        = 1'b1;
            cmd_o.fin_rd     = !stat_i.slot_empty;
            cmd_o.fin_status = stat_i.slot_empty ? ST_NOTFOUND : ST_OK;
            state_d          = S_IDLE;
          end
          REQ_DEL: begin
            cmd_o.wr_del     = !stat_i.slot_empty;
            cmd_o.fin        = 1'b1;
            cmd_o.fin_status = stat_i.slot_empty ? ST_NOTFOUND : ST_OK;
            state_d          = S_IDLE;
          end
          REQ_PUT: begin
            cmd_o.wr_put     = 1'b1;
            cmd_o.fin        = 1'b1;
            cmd_o.fin_status = ST_OK;
            state_d          = S_IDLE;
          end
          default: begin
            if (stat_i.slot_empty) begin
              cmd_o.fin            = 1'b1;
              cmd_o.fin_found_slot = 1'b1;
              cmd_o.fin_status     = ST_OK;
              state_d              = S_IDLE;
            end else if (stat_i.slot_last) begin
              state_d = S_NEXT;
            end else begin
              cmd_o.slot_inc = 1'b1;
              state_d        = S_SCAN;
            end
          end
        endcase
      end
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (stat_i.fill_last) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = ST_OK;
          state_d          = S_IDLE;
        end
      end
      S_LOOP: begin
        if (stat_i.loop_stop) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = ST_NOFREE;
          state_d          = S_IDLE;
        end else begin
          cmd_o.srch_init = 1'b1;
          state_d         = S_SEARCH;
        end
      end
      S_SCAN: begin
        if (stat_i.slot_at_end) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = ST_NOFREE;
          state_d          = S_IDLE;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_CHECK;
        end
      end
      S_NEXT: begin
        if (stat_i.page_top) begin
          cmd_o.fin        = 1'b1;
          cmd_o.fin_status = ST_NOFREE;
          state_d          = S_IDLE;
        end else begin
          cmd_o.next_page = 1'b1;
          state_d         = S_LOOP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hdl/spim_datapath.sv
// Datapath of the sparse paged ID map: directory registers, slot memory,
// search and scan registers, table counters and result registers. Uses spim_pkg.
module spim_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  spim_pkg::ctl_cmd_t          cmd_i,
  output spim_pkg::dp_stat_t          stat_o,
  input  logic [2:0]                  req_type_i,
  input  logic [spim_pkg::ID_W-1:0]   id_i,
  input  logic [spim_pkg::ID_W-1:0]   alloc_limit_i,
  input  logic [63:0]                 value_w0_i,
  input  logic [63:0]                 value_w1_i,
  input  logic [63:0]                 value_w2_i,
  input  logic [63:0]                 value_w3_i,
  output logic                        done_o,
  output logic [2:0]                  status_o,
  output logic [spim_pkg::VAL_W-1:0]  read_o,
  output logic [spim_pkg::ID_W-1:0]   found_id_o,
  output logic [spim_pkg::TOT_W-1:0]  total_entries_o,
  output logic [spim_pkg::CNT_W-1:0]  live_pages_o
);
  import spim_pkg::*;

  // Request registers.
  logic [2:0]        req_q;
  logic [ID_W-1:0]   id_q;
  logic [ID_W-1:0]   end_q;
  logic [VAL_W-1:0]  val_q;
  logic [ITER_W-1:0] iter_q;
  logic [CNT_W-1:0]  lo_q, hi_q;
  logic [SLOT_W-1:0] slot_q, clr_q;

  // Directory and table counters.
  logic [PAGE_W-1:0] page_q  [DIR_DEPTH];
  logic [POP_W-1:0]  pop_q   [DIR_DEPTH];
  logic [DIR_W-1:0]  frame_q [DIR_DEPTH];
  logic [CNT_W-1:0]  used_q;
  logic [TOT_W-1:0]  total_q;
  logic [CNT_W-1:0]  live_q;

  // Slot memory.
  logic [VAL_W-1:0]  mem [MEM_DEPTH];
  logic [VAL_W-1:0]  rdata_q;

  // Results.
  logic              done_q;
  logic [2:0]        status_q;
  logic [VAL_W-1:0]  rd_q;
  logic [ID_W-1:0]   found_q;

  logic [PAGE_W-1:0]  page_w;
  logic [DIR_W-1:0]   pos;
  logic [DIR_W-1:0]   pos_frame;
  logic [POP_W-1:0]   pos_pop;
  logic [CNT_W-1:0]   mid;
  logic [ID_W:0]      end_sum;
  logic [ID_W-1:0]    end_new;
  logic [MADDR_W-1:0] waddr, raddr;
  logic [VAL_W-1:0]   wdata;
  logic               we;
  logic               has;

  assign page_w    = id_q[ID_W-1:SLOT_W];
  assign pos       = lo_q[DIR_W-1:0];
  assign pos_frame = frame_q[pos];
  assign pos_pop   = pop_q[pos];
  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign has       = (lo_q < used_q) && (page_q[pos] == page_w);

  // Search end for allocate: start plus span, saturated; a zero span is unbounded.
  assign end_sum = {1'b0, id_i} + {1'b0, alloc_limit_i};
  assign end_new = ((alloc_limit_i == '0) || end_sum[ID_W]) ? '1 : end_sum[ID_W-1:0];

  // Status to the controller.
  always_comb begin
    stat_o.req         = req_q;
    stat_o.val_zero    = (val_q == '0);
    stat_o.srch_done   = !(lo_q < hi_q);
    stat_o.has         = has;
    stat_o.dir_full    = (used_q == CNT_W'(DIR_DEPTH));
    stat_o.pop_full    = (pos_pop == POP_W'(PAGE_SLOTS));
    stat_o.slot_empty  = (rdata_q == '0);
    stat_o.slot_last   = &slot_q;
    stat_o.slot_at_end = ({page_w, slot_q} >= end_q);
    stat_o.loop_stop   = (iter_q >= ITER_W'(MAX_ITER)) || (id_q >= end_q);
    stat_o.page_top    = &page_w;
    stat_o.fill_last   = &clr_q;
  end

  // Memory port selection: the fill sweep writes zeros, or the new value at its slot.
  assign raddr = {pos_frame, slot_q};
  assign waddr = cmd_i.fill_step ? {pos_frame, clr_q} : {pos_frame, slot_q};
  assign we    = cmd_i.fill_step || cmd_i.wr_put || cmd_i.wr_del;
  always_comb begin
    if (cmd_i.fill_step) begin
      wdata = (clr_q == slot_q) ? val_q : '0;
    end else if (cmd_i.wr_put) begin
      wdata = val_q;
    end else begin
      wdata = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= mem[raddr];
    end
  end

  // Request, search and scan registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      id_q   <= id_i;
      end_q  <= end_new;
      val_q  <= {value_w3_i, value_w2_i, value_w1_i, value_w0_i};
      iter_q <= '0;
    end
    if (cmd_i.next_page) begin
      id_q   <= {page_w + PAGE_W'(1), {SLOT_W{1'b0}}};
      iter_q <= iter_q + ITER_W'(1);
    end
    if (cmd_i.srch_init) begin
      lo_q <= '0;
      hi_q <= used_q;
    end else if (cmd_i.srch_step) begin
      if (page_q[mid[DIR_W-1:0]] < page_w) begin
        lo_q <= mid + CNT_W'(1);
      end else begin
        hi_q <= mid;
      end
    end
    if (cmd_i.slot_init) begin
      slot_q <= id_q[SLOT_W-1:0];
    end else if (cmd_i.slot_inc) begin
      slot_q <= slot_q + SLOT_W'(1);
    end
    if (cmd_i.create) begin
      clr_q <= '0;
    end else if (cmd_i.fill_step) begin
      clr_q <= clr_q + SLOT_W'(1);
    end
  end

  // Directory entries: insertion shifts the tail up by one place.
  always_ff @(posedge clk_i) begin
    if (cmd_i.create) begin
      for (int i = 1; i < DIR_DEPTH; i++) begin
        if ((CNT_W'(i) > lo_q) && (CNT_W'(i) <= used_q)) begin
          page_q[i]  <= page_q[i-1];
          pop_q[i]   <= pop_q[i-1];
          frame_q[i] <= frame_q[i-1];
        end
      end
      page_q[pos]  <= page_w;
      pop_q[pos]   <= POP_W'(1);
      frame_q[pos] <= used_q[DIR_W-1:0];
    end else if (cmd_i.wr_put && (rdata_q == '0)) begin
      pop_q[pos] <= pos_pop + POP_W'(1);
    end else if (cmd_i.wr_del) begin
      pop_q[pos] <= pos_pop - POP_W'(1);
    end
  end

  // Table counters kept alongside the directory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      total_q <= '0;
      live_q  <= '0;
    end else if (cmd_i.clear_all) begin
      used_q  <= '0;
      total_q <= '0;
      live_q  <= '0;
    end else if (cmd_i.create) begin
      used_q  <= used_q + CNT_W'(1);
      total_q <= total_q + TOT_W'(1);
      live_q  <= live_q + CNT_W'(1);
    end else if (cmd_i.wr_put && (rdata_q == '0)) begin
      total_q <= total_q + TOT_W'(1);
      if (pos_pop == '0) begin
        live_q <= live_q + CNT_W'(1);
      end
    end else if (cmd_i.wr_del) begin
      total_q <= total_q - TOT_W'(1);
      if (pos_pop == POP_W'(1)) begin
        live_q <= live_q - CNT_W'(1);
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.fin;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      status_q <= cmd_i.fin_status;
      rd_q     <= cmd_i.fin_rd ? rdata_q : '0;
      if (cmd_i.fin_found_id) begin
        found_q <= id_q;
      end else if (cmd_i.fin_found_slot) begin
        found_q <= {page_w, slot_q};
      end else begin
        found_q <= '0;
      end
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign read_o          = rd_q;
  assign found_id_o      = found_q;
  assign total_entries_o = total_q;
  assign live_pages_o    = live_q;

endmodule

FILE: tb/sparse_paged_id_map_core_test.sv
// Self-checking testbench for sparse_paged_id_map_core: directed and random
// get/put/delete/allocate/clear requests checked against a behavioral table.
// Depends on spim_pkg and the sparse_paged_id_map_core RTL.
`timescale 1ns / 100ps

module sparse_paged_id_map_core_test;
  import spim_pkg::*;

  localparam logic [63:0] ID_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [57:0] TOP_PAGE = {58{1'b1}};
  localparam int          POOL_N  = 22;

  typedef struct packed {
    logic [2:0]       status;
    logic [255:0]     rd;
    logic [63:0]      found;
    logic [TOT_W-1:0] total;
    logic [CNT_W-1:0] live;
  } map_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [2:0] req_type_i = REQ_GET;
  logic [63:0] id_i = '0;
  logic [63:0] alloc_limit_i = '0;
  logic [63:0] value_w0_i = '0, value_w1_i = '0, value_w2_i = '0, value_w3_i = '0;
  logic done_o;
  logic [2:0] status_o;
  logic [63:0] read_w0_o, read_w1_o, read_w2_o, read_w3_o, found_id_o;
  logic [TOT_W-1:0] total_entries_o;
  logic [CNT_W-1:0] live_pages_o;

  sparse_paged_id_map_core dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Behavioral copy of the table.
  logic [57:0]  page_tag [DIR_DEPTH];
  int           page_pop [DIR_DEPTH];
  int           pages_used;
  logic [255:0] slot_mem [DIR_DEPTH][PAGE_SLOTS];

  map_result_t  expected_results[$];
  int           errors = 0;
  logic [57:0]  page_pool [POOL_N];

  function automatic int page_lookup(logic [57:0] page);
    int lo, hi, mid;
    lo = 0;
    hi = pages_used;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (page_tag[mid] < page) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic bit page_present(int pos, logic [57:0] page);
    return pos < pages_used && page_tag[pos] == page;
  endfunction

  // First empty id in [start, end); returns 0 when the search gives up.
  function automatic bit free_id_search(logic [63:0] start, logic [63:0] lim,
                                        output logic [63:0] found);
    logic [63:0] stop, cur, base;
    logic [57:0] page;
    int pos, s;
    found = '0;
    if (lim == 0) stop = ID_MAX;
    else stop = (lim > ID_MAX - start) ? ID_MAX : start + lim;
    cur = start;
    for (int iter = 0; iter < DIR_DEPTH + 2 && cur < stop; iter++) begin
      page = cur[63:6];
      s = int'(cur[5:0]);
      pos = page_lookup(page);
      base = {page, 6'd0};
      if (!page_present(pos, page)) begin
        found = cur;
        return 1'b1;
      end
      if (page_pop[pos] < PAGE_SLOTS) begin
        for (; s < PAGE_SLOTS; s++) begin
          if (64'(s) > ID_MAX - base) return 1'b0;
          if (base + 64'(s) >= stop) return 1'b0;
          if (slot_mem[pos][s] == '0) begin
            found = base + 64'(s);
            return 1'b1;
          end
        end
      end
      if (page == TOP_PAGE) return 1'b0;
      cur = {page + 58'd1, 6'd0};
    end
    return 1'b0;
  endfunction

  // Applies one request to the table and returns the result it must give.
  function automatic map_result_t apply_request(logic [2:0] req, logic [63:0] id,
                                                logic [63:0] lim, logic [255:0] val);
    map_result_t r;
    logic [57:0] page;
    int slot, pos;
    logic [63:0] fid;
    r = '0;
    page = id[63:6];
    slot = int'(id[5:0]);
    pos = page_lookup(page);
    case (req)
      REQ_GET, REQ_DEL: begin
        if (!page_present(pos, page) || slot_mem[pos][slot] == '0) begin
          r.status = ST_NOTFOUND;
        end else if (req == REQ_GET) begin
          r.rd = slot_mem[pos][slot];
        end else begin
          slot_mem[pos][slot] = '0;
          page_pop[pos]--;
        end
      end
      REQ_PUT: begin
        if (val == '0) begin
          r.status = ST_INVAL;
        end else if (!page_present(pos, page) && pages_used >= DIR_DEPTH) begin
          r.status = ST_DIRFULL;
        end else begin
          if (!page_present(pos, page)) begin
            for (int i = pages_used; i > pos; i--) begin
              page_tag[i] = page_tag[i-1];
              page_pop[i] = page_pop[i-1];
              for (int s = 0; s < PAGE_SLOTS; s++) slot_mem[i][s] = slot_mem[i-1][s];
            end
            page_tag[pos] = page;
            page_pop[pos] = 0;
            for (int s = 0; s < PAGE_SLOTS; s++) slot_mem[pos][s] = '0;
            pages_used++;
          end
          if (slot_mem[pos][slot] == '0) page_pop[pos]++;
          slot_mem[pos][slot] = val;
        end
      end
      REQ_ALLOC: begin
        if (free_id_search(id, lim, fid)) r.found = fid;
        else r.status = ST_NOFREE;
      end
      REQ_CLEAR: pages_used = 0;
      default: ;
    endcase
    for (int i = 0; i < pages_used; i++) begin
      r.total += TOT_W'(page_pop[i]);
      if (page_pop[i] != 0) r.live++;
    end
    return r;
  endfunction

  // Drives one request and waits for its transfer.
  task automatic send_req(logic [2:0] req, logic [63:0] id, logic [63:0] lim,
                          logic [255:0] val);
    @(negedge clk_i);
    req_type_i = req;
    id_i = id;
    alloc_limit_i = lim;
    {value_w3_i, value_w2_i, value_w1_i, value_w0_i} = val;
    start_i = 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_results.push_back(apply_request(req, id, lim, val));
  endtask

  task automatic pause(int cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // Holds the sender until every outstanding result has come back.
  task automatic drain();
    pause(1);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [255:0] rand_value();
    logic [255:0] v;
    int pick;
    pick = $urandom_range(0, 19);
    v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (pick == 0) v = '0;
    else if (pick == 1) v = 256'd1 << $urandom_range(0, 255);
    else if (pick == 2) v = '1;
    return v;
  endfunction

  function automatic logic [63:0] rand_id();
    logic [5:0] slot;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    slot = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
    return {page_pool[$urandom_range(0, POOL_N - 1)], slot};
  endfunction

  function automatic logic [63:0] rand_limit(logic [63:0] start);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 64'($urandom_range(1, 3));
      2: return 64'($urandom_range(1, 300));
      3: return ID_MAX;
      4: return ID_MAX - start;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Extremes of the fields, every request kind and the odd request codes.
  task automatic test_basic();
    send_req(REQ_GET, 64'd0, '0, '0);
    send_req(REQ_DEL, ID_MAX, '0, '0);
    send_req(REQ_PUT, 64'd5, '0, '0);
    send_req(REQ_PUT, 64'd5, '0, '1);
    send_req(REQ_PUT, 64'd5, '0, 256'hA5);
    send_req(REQ_GET, 64'd5, '0, '0);
    send_req(REQ_PUT, ID_MAX, '1, {4{64'hDEAD_BEEF_0123_4567}});
    send_req(REQ_GET, ID_MAX, '0, '0);
    send_req(REQ_ALLOC, 64'd5, '0, '0);
    send_req(REQ_ALLOC, 64'd5, 64'd1, '0);
    send_req(REQ_ALLOC, ID_MAX - 64'd1, '0, '0);
    send_req(REQ_DEL, 64'd5, '0, '0);
    send_req(REQ_DEL, 64'd5, '0, '0);
    send_req(REQ_GET, 64'd5, '0, '0);
    send_req(3'd5, ID_MAX, ID_MAX, '1);
    send_req(3'd6, '0, '0, '0);
    send_req(3'd7, ID_MAX, ID_MAX, '1);
    send_req(REQ_CLEAR, '0, '0, '0);
    send_req(REQ_GET, ID_MAX, '0, '0);
  endtask

  // One page more than the directory holds, then a put to an emptied page.
  task automatic test_dir_full();
    for (int p = 0; p <= DIR_DEPTH; p++)
      send_req(REQ_PUT, {58'(p * 3), 6'(p)}, '0, rand_value() | 256'd1);
    send_req(REQ_DEL, {58'd0, 6'd0}, '0, '0);
    send_req(REQ_PUT, {58'd0, 6'd1}, '0, 256'd7);
    send_req(REQ_CLEAR, '0, '0, '0);
  endtask

  // Allocation across a full page and at the top of the id space.
  task automatic test_alloc_scan();
    for (int s = 0; s < PAGE_SLOTS; s++) send_req(REQ_PUT, {58'd3, 6'(s)}, '0, 256'(s + 1));
    send_req(REQ_ALLOC, {58'd3, 6'd0}, '0, '0);
    send_req(REQ_ALLOC, {58'd3, 6'd10}, 64'd54, '0);
    for (int s = 0; s < PAGE_SLOTS - 1; s++) send_req(REQ_PUT, {TOP_PAGE, 6'(s)}, '0, '1);
    send_req(REQ_ALLOC, {TOP_PAGE, 6'd0}, '0, '0);
    send_req(REQ_ALLOC, {TOP_PAGE, 6'd4}, ID_MAX, '0);
    send_req(REQ_ALLOC, ID_MAX, '0, '0);
    send_req(REQ_DEL, {TOP_PAGE, 6'd9}, '0, '0);
    send_req(REQ_ALLOC, {TOP_PAGE, 6'd0}, '0, '0);
  endtask

  // Random requests over a small set of pages, sent in bursts.
  task automatic test_random(int count);
    logic [63:0] id;
    int sent, burst, kind;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && sent < count; b++) begin
        id = rand_id();
        kind = $urandom_range(0, 99);
        if (kind < 25) send_req(REQ_GET, id, rand_limit(id), rand_value());
        else if (kind < 60) send_req(REQ_PUT, id, rand_limit(id), rand_value());
        else if (kind < 78) send_req(REQ_DEL, id, rand_limit(id), rand_value());
        else if (kind < 97) send_req(REQ_ALLOC, id, rand_limit(id), rand_value());
        else if (kind < 98) send_req(REQ_CLEAR, id, rand_limit(id), rand_value());
        else send_req(3'($urandom_range(5, 7)), id, rand_limit(id), rand_value());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
    end
  endtask

  // Compares each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    map_result_t got, want;
    if (rst_ni && done_o) begin
      got = '{status_o, {read_w3_o, read_w2_o, read_w1_o, read_w0_o}, found_id_o,
              total_entries_o, live_pages_o};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, status_o);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.rd !== want.rd) begin
          $display("%0t: read data expected %h actual %h", $time, want.rd, got.rd);
          errors++;
        end
        if (got.found !== want.found) begin
          $display("%0t: found_id expected %h actual %h", $time, want.found, got.found);
          errors++;
        end
        if (got.total !== want.total) begin
          $display("%0t: total_entries expected %0d actual %0d", $time, want.total,
                   got.total);
          errors++;
        end
        if (got.live !== want.live) begin
          $display("%0t: live_pages expected %0d actual %0d", $time, want.live, got.live);
          errors++;
        end
      end
    end
  end

  initial begin
    pages_used = 0;
    page_pool[0] = '0;
    page_pool[1] = 58'd1;
    page_pool[2] = TOP_PAGE;
    page_pool[3] = TOP_PAGE - 58'd1;
    for (int i = 4; i < POOL_N; i++) page_pool[i] = 58'({$urandom, $urandom});
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_basic();
    drain();
    test_dir_full();
    test_alloc_scan();
    drain();
    test_random(1630);
    drain();
    repeat (3000) @(posedge clk_i);
    if (errors == 0) $display("** sparse_paged_id_map_core: PASSED **");
    else $display("** sparse_paged_id_map_core: FAILED **");
    $finish;
  end

  // Worst case is an allocate scan of many pages per request.
  initial begin
    #40_000_000;
    $display("** sparse_paged_id_map_core: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
hdl/spim_pkg.sv
hdl/spim_ctrl.sv
hdl/spim_datapath.sv
hdl/sparse_paged_id_map_core.sv
tb/sparse_paged_id_map_core_test.sv
